// ===== hw/rtl/pdt_pkg.sv =====
// Shared types, constants and helpers for the PPS-disciplined ms timestamp.
// Used by pdt_round, pdt_core and pps_disciplined_ms_timestamp; no dependencies.
package pdt_pkg;

	// Timestamp and register widths
	localparam int TIME_WIDTH = 48;
	localparam int TICK_W     = 10;
	localparam int TMO_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int MS_W       = 10;
	localparam int SUM_W      = 12;

	localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(10);
	localparam logic [TMO_W-1:0]  TMO_RST  = TMO_W'(10000);

	// Milliseconds per second and the residue of the wrap span
	localparam int MS_PER_S = 1000;
	localparam logic [64:0] TIME_SPAN = 65'd1 << TIME_WIDTH;
	localparam int WRAP_MOD = int'(TIME_SPAN % 65'd1000);
	// Residue of a whole-second value once it has wrapped past the top
	localparam int WRAPPED_R_MOD = (MS_PER_S - WRAP_MOD) % MS_PER_S;

	// Rounding unit: fold 10-bit chunks by their weight 2^(10k) mod 1000
	localparam int CHUNK_W   = 10;
	localparam int FOLD_N    = 7;
	localparam int FOLD_IN_W = FOLD_N * CHUNK_W;
	localparam int FOLD_W    = 22;
	localparam logic [FOLD_N-1:0][CHUNK_W-1:0] FOLD_WT = {
		10'd976, 10'd624, 10'd776, 10'd824, 10'd576, 10'd24, 10'd1
	};

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [MS_W-1:0]       ms_t;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_PPS     = 2'd1,
		OP_SET_GPS = 2'd2
	} op_t;

	typedef enum logic {
		CFG_TICK_MS      = 1'b0,
		CFG_SYNC_TIMEOUT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RND_IDLE,
		RND_FOLD,
		RND_REDUCE,
		RND_FINISH
	} rnd_state_t;

	// Rounding unit status toward the core
	typedef struct packed {
		logic  busy;
		time_t value;
		ms_t   value_mod;
	} rnd_stat_t;

	// One result as held in the core's state
	typedef struct packed {
		time_t time_now;
		logic  sample_strobe;
		logic  synced;
		logic  time_error;
	} result_t;

	// Reduce a value below 4000 modulo one thousand
	function automatic ms_t red_ms(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		begin
			if (v >= SUM_W'(3 * MS_PER_S)) begin
				r = v - SUM_W'(3 * MS_PER_S);
			end else if (v >= SUM_W'(2 * MS_PER_S)) begin
				r = v - SUM_W'(2 * MS_PER_S);
			end else if (v >= SUM_W'(MS_PER_S)) begin
				r = v - SUM_W'(MS_PER_S);
			end else begin
				r = v;
			end
			red_ms = r[MS_W-1:0];
		end
	endfunction

	// Weighted chunk sum; congruent to the input modulo one thousand
	function automatic logic [FOLD_W-1:0] fold_ms(input logic [FOLD_IN_W-1:0] v);
		logic [FOLD_W-1:0] acc;
		begin
			acc = '0;
			for (int k = 0; k < FOLD_N; k++) begin
				acc = acc + FOLD_W'(v[k*CHUNK_W +: CHUNK_W]) * FOLD_W'(FOLD_WT[k]);
			end
			fold_ms = acc;
		end
	endfunction

endpackage

// ===== hw/rtl/pdt_round.sv =====
// GPS time store and round-up-to-whole-second unit.
// Depends on pdt_pkg; folds the GPS time to its residue mod 1000 in the fold and reduce states.
module pdt_round
	import pdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  time_t     gps_time,
	output rnd_stat_t stat
);

	rnd_state_t          state_q, state_d;
	time_t               gps_q;
	logic [FOLD_W-1:0]   fold_q;
	ms_t                 rem_q;
	time_t               value_q;
	ms_t                 value_mod_q;

	logic [FOLD_W-1:0]   fold_b;
	ms_t                 pad;
	logic [TIME_WIDTH:0] round_sum;

	// Finish the fold, then pad up to the next whole second
	always_comb begin
		fold_b    = fold_ms(FOLD_IN_W'(fold_ms(FOLD_IN_W'(fold_q))));
		pad       = (rem_q == '0) ? '0 : MS_W'(MS_PER_S - int'(rem_q));
		round_sum = {1'b0, gps_q} + {{(TIME_WIDTH+1-MS_W){1'b0}}, pad};
	end

	// Sequence: idle, fold, reduce, finish
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RND_IDLE: begin
				if (start) state_d = RND_FOLD;
			end
			RND_FOLD: begin
				state_d = RND_REDUCE;
			end
			RND_REDUCE: begin
				state_d = RND_FINISH;
			end
			RND_FINISH: begin
				state_d = RND_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RND_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the GPS time, fold it once, then reduce to the remainder
	always_ff @(posedge clk) begin
		if (state_q == RND_IDLE && start) begin
			gps_q <= gps_time;
		end else if (state_q == RND_FOLD) begin
			fold_q <= fold_ms(FOLD_IN_W'(gps_q));
		end else if (state_q == RND_REDUCE) begin
			rem_q <= red_ms(SUM_W'(fold_b));
		end
	end

	// Rounded value; zero after reset matches a zero GPS time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q     <= '0;
			value_mod_q <= '0;
		end else if (state_q == RND_FINISH) begin
			value_q     <= round_sum[TIME_WIDTH-1:0];
			value_mod_q <= round_sum[TIME_WIDTH] ? MS_W'(WRAPPED_R_MOD) : '0;
		end
	end

	assign stat.busy      = (state_q != RND_IDLE);
	assign stat.value     = value_q;
	assign stat.value_mod = value_mod_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == RND_IDLE) else $error("round start while busy");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RND_REDUCE |=> rem_q < MS_W'(MS_PER_S)) else $error("remainder out of range");
	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RND_FINISH |=> state_q == RND_IDLE) else $error("finish not followed by idle");

endmodule

// ===== hw/rtl/pdt_core.sv =====
// Timestamp state and single-pass update for tick, PPS and set-GPS requests.
// Depends on pdt_pkg; takes the rounded GPS time from pdt_round.
module pdt_core
	import pdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  op_t               op,
	input  logic [TICK_W-1:0] tick_ms,
	input  logic [TMO_W-1:0]  sync_timeout_ms,
	input  rnd_stat_t         rnd,
	output logic              rnd_start,
	output result_t           result
);

	time_t cur_q, cur_d;
	ms_t   mod_q, mod_d;
	time_t last_pps_q, last_pps_d;
	logic  sync_q, sync_d;
	logic  err_q, err_d;
	logic  strobe_q, strobe_d;

	logic [TIME_WIDTH:0] tick_sum;
	logic [TIME_WIDTH:0] deadline;
	logic [SUM_W-1:0]    mod_sum;
	time_t               tick_cur;
	ms_t                 tick_mod;
	logic                tick_sync;
	logic                will_tick;
	time_t               c1;
	ms_t                 m1;
	logic                s1;

	// Tick arithmetic: advance time, track residue, test the sync deadline
	always_comb begin
		tick_sum  = {1'b0, cur_q} + (TIME_WIDTH+1)'(tick_ms);
		deadline  = {1'b0, last_pps_q} + (TIME_WIDTH+1)'(sync_timeout_ms);
		mod_sum   = SUM_W'(mod_q) + SUM_W'(tick_ms)
			+ (tick_sum[TIME_WIDTH] ? SUM_W'(WRAPPED_R_MOD) : '0);
		tick_cur  = tick_sum[TIME_WIDTH-1:0];
		tick_mod  = red_ms(mod_sum);
		tick_sync = sync_q && !({1'b0, tick_cur} > deadline);
		will_tick = (tick_ms <= TICK_W'(MS_PER_S))
			&& ({1'b0, mod_q} == (MS_W+1)'((MS_W+1)'(MS_PER_S) - (MS_W+1)'(tick_ms)));
	end

	// Next state per request
	always_comb begin
		cur_d      = cur_q;
		mod_d      = mod_q;
		last_pps_d = last_pps_q;
		sync_d     = sync_q;
		err_d      = err_q;
		strobe_d   = 1'b0;
		c1         = will_tick ? tick_cur : cur_q;
		m1         = will_tick ? tick_mod : mod_q;
		s1         = will_tick ? tick_sync : sync_q;
		unique case (op)
			OP_TICK: begin
				cur_d    = tick_cur;
				mod_d    = tick_mod;
				sync_d   = tick_sync;
				strobe_d = 1'b1;
			end
			OP_PPS: begin
				strobe_d = will_tick;
				cur_d    = c1;
				mod_d    = m1;
				sync_d   = s1;
				// Load the whole second; a mismatch while synced is an error
				if (rnd.value != '0) begin
					cur_d  = rnd.value;
					mod_d  = rnd.value_mod;
					sync_d = 1'b1;
					err_d  = err_q || (s1 && (c1 != rnd.value));
				end
				last_pps_d = cur_d;
			end
			OP_SET_GPS: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			mod_q      <= '0;
			last_pps_q <= '0;
			sync_q     <= 1'b0;
			err_q      <= 1'b0;
			strobe_q   <= 1'b0;
		end else if (adv) begin
			cur_q      <= cur_d;
			mod_q      <= mod_d;
			last_pps_q <= last_pps_d;
			sync_q     <= sync_d;
			err_q      <= err_d;
			strobe_q   <= strobe_d;
		end
	end

	assign rnd_start = adv && (op == OP_SET_GPS);

	assign result.time_now      = cur_q;
	assign result.sample_strobe = strobe_q;
	assign result.synced        = sync_q;
	assign result.time_error    = err_q;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q) else $error("error flag dropped");
	a_pps_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op == OP_PPS && rnd.value != '0 |=> sync_q && cur_q == $past(rnd.value))
		else $error("PPS did not load rounded time");
	a_pps_mark: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op == OP_PPS |=> last_pps_q == cur_q) else $error("PPS time not recorded");

endmodule

// ===== hw/rtl/pps_disciplined_ms_timestamp.sv =====
// Top level of the PPS-disciplined millisecond timestamp: handshakes and config.
// Depends on pdt_pkg, pdt_round and pdt_core.
//
//   channel | signals                                  | direction
//   in      | in_valid, in_stall, op, gps_time         | request in
//   out     | out_valid, out_stall, time_now, flags    | result out
//   cfg     | cfg_we, cfg_index, cfg_data              | register write
//
// One request per cycle for ticks and PPS pulses while out is not stalled and the
// rounding unit is idle; an accepted request updates the state as it advances.
// A set-GPS request starts the rounding unit, busy through its fold, reduce and
// finish states, while the next request waits in the input register. Reset clears
// the timestamp, flags and valids and loads default register values. A stall on
// out holds the result and backs up into in_stall.
module pps_disciplined_ms_timestamp
	import pdt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [TIME_WIDTH-1:0] gps_time,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TIME_WIDTH-1:0] time_now,
	output logic                  sample_strobe,
	output logic                  synced,
	output logic                  time_error,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic              valid_s1;
	op_t               op_s1;
	time_t             gps_s1;
	logic              out_valid_q;
	logic [TICK_W-1:0] tick_ms_q;
	logic [TMO_W-1:0]  timeout_q;
	logic              adv;
	logic              rnd_start;
	rnd_stat_t         rnd;
	result_t           result;

	// Advance the held request into the state when the result slot frees up and the rounding unit is idle
	assign adv      = valid_s1 && !rnd.busy && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= op_t'(op);
			gps_s1 <= gps_time;
		end
	end

	// Result valid; payload is the core state itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q <= TICK_RST;
			timeout_q <= TMO_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TICK_MS:      tick_ms_q <= cfg_data[TICK_W-1:0];
				CFG_SYNC_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pdt_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rnd_start),
		.gps_time (gps_s1),
		.stat     (rnd)
	);

	pdt_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.op              (op_s1),
		.tick_ms         (tick_ms_q),
		.sync_timeout_ms (timeout_q),
		.rnd             (rnd),
		.rnd_start       (rnd_start),
		.result          (result)
	);

	assign out_valid     = out_valid_q;
	assign time_now      = result.time_now;
	assign sample_strobe = result.sample_strobe;
	assign synced        = result.synced;
	assign time_error    = result.time_error;

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rnd.busy |-> !adv) else $error("request advanced while rounding");
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q) else $error("advanced request produced no result");
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1) else $error("stall with empty input register");

endmodule
